FILE: design/sha_pkg.sv
// Shared constants, types and round functions for the SHA-256 hasher.
package sha_pkg;

   // Word and block geometry
   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int CHAIN_WORDS = 8;
   localparam int ROUNDS      = 64;
   localparam int COUNT_W     = 61;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // Round constants
   localparam logic [31:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Initial hash value
   localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Memory port requests from the compression engine, plus its done strobe
   typedef struct packed {
      logic [3:0]  buf_raddr;
      logic [2:0]  chain_raddr;
      logic        chain_we;
      logic [2:0]  chain_waddr;
      logic [31:0] chain_wdata;
      logic        done;
   } core_port_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

FILE: design/sha_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

FILE: design/sha_core.sv
// Compression engine: chain load, 64 rounds with rolling schedule, chain update.
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           buf_rdata,
   input  logic [31:0]           chain_rdata,
   output sha_pkg::core_port_type port
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_LOAD  = 2'd1;
   localparam logic [1:0] PH_ROUND = 2'd2;
   localparam logic [1:0] PH_FIN   = 2'd3;

   localparam logic [5:0] CNT_CHAIN_END = 6'd8;
   localparam logic [5:0] CNT_ROUND_END = 6'd63;

   logic [1:0]  phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] wnext_ff, wnext_in;

   logic [5:0]  cnt_dec;
   logic [2:0]  slot;
   logic [31:0] wt;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] ch;
   logic [31:0] maj;

   // Round datapath: a..h live in v_ff[0..7]
   always_comb begin
      cnt_dec = cnt_ff - 6'd1;
      slot    = cnt_dec[2:0];
      // first sixteen words come straight from the block buffer
      wt  = (cnt_ff[5:4] == 2'b00) ? buf_rdata : wnext_ff;
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1  = v_ff[7] + sha_pkg::big_sigma1(v_ff[4]) + ch + sha_pkg::ROUND_K[cnt_ff] + wt;
      t2  = sha_pkg::big_sigma0(v_ff[0]) + maj;
   end

   // Memory requests
   always_comb begin
      port.buf_raddr   = (phase_ff == PH_LOAD) ? 4'd0 : (cnt_ff[3:0] + 4'd1);
      port.chain_raddr = cnt_ff[2:0];
      port.chain_we    = (phase_ff == PH_FIN) && (cnt_ff != 6'd0);
      port.chain_waddr = slot;
      port.chain_wdata = v_ff[slot] + chain_rdata;
      port.done        = (phase_ff == PH_FIN) && (cnt_ff == CNT_CHAIN_END);
   end

   // Sequencer and next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      wnext_in = wnext_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_LOAD;
               cnt_in   = 6'd0;
            end
         end
         PH_LOAD: begin
            if (cnt_ff != 6'd0) begin
               v_in[slot] = chain_rdata;
            end
            if (cnt_ff == CNT_CHAIN_END) begin
               phase_in = PH_ROUND;
               cnt_in   = 6'd0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         PH_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            // schedule word for the next round, computed ahead into a register
            wnext_in = sha_pkg::small_sigma1(w_ff[15]) + w_ff[10]
                     + sha_pkg::small_sigma0(w_ff[2]) + w_ff[1];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = wt;
            if (cnt_ff == CNT_ROUND_END) begin
               phase_in = PH_FIN;
               cnt_in   = 6'd0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         PH_FIN: begin
            if (cnt_ff == CNT_CHAIN_END) begin
               phase_in = PH_IDLE;
               cnt_in   = 6'd0;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= 6'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      w_ff     <= w_in;
      wnext_ff <= wnext_in;
   end

endmodule

FILE: design/sha256_message_hasher.sv
// SHA-256 hasher top level: byte packing, padding, control and digest output.
//
//   channel   dir   tdata                    tuser              tlast
//   req_      in    [7:0] msg_byte           byte_present       end_of_message
//   rsp_      out   [31:0] digest_word       [2:0] word_number  last_word
//
// A byte beat is accepted while the sequencer is idle; a beat that completes a
// 64-byte block starts a compression (chain load, 64 rounds on the single round
// unit, chain write-back), during which req_tready is low. An end beat adds
// padding writes (up to 16 words per block) and one or two compressions, then
// eight digest beats, each a chain read followed by a load of the output register.
// Reset is synchronous; the chain memory reads as the initial hash until the
// first block of a message is folded in. rsp_tready low only stalls the digest.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] byte_present
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_number
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_COMP   = 3'd2;
   localparam logic [2:0] ST_OUT_RD = 3'd3;
   localparam logic [2:0] ST_OUT_LD = 3'd4;

   localparam logic [5:0] POS_LAST_BYTE = 6'd63;
   localparam logic [5:0] POS_NO_LENGTH = 6'd56;
   localparam logic [3:0] WIDX_LEN_HI   = 4'd14;
   localparam logic [3:0] WIDX_LAST     = 4'd15;
   localparam logic [2:0] ONUM_LAST     = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [sha_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [31:0]                  word_ff, word_in;
   logic                         end_ff, end_in;
   logic                         pad_two_ff, pad_two_in;
   logic                         pad_first_ff, pad_first_in;
   logic [3:0]                   widx_ff, widx_in;
   logic                         final_ff, final_in;
   logic                         fresh_ff, fresh_in;
   logic [2:0]                   onum_ff, onum_in;
   logic [2:0]                   raddr_q_ff;
   logic [31:0]                  rsp_word_ff, rsp_word_in;
   logic [2:0]                   rsp_num_ff, rsp_num_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic                         req_accept;
   logic [5:0]                   pos;
   logic [5:0]                   end_pos;
   logic [31:0]                  byte_word;
   logic [31:0]                  pad_word;
   logic [31:0]                  pad_data;
   logic                         buf_we;
   logic [3:0]                   buf_waddr;
   logic [31:0]                  buf_wdata;
   logic [31:0]                  buf_rdata;
   logic [2:0]                   chain_raddr;
   logic [31:0]                  chain_ram_rdata;
   logic [31:0]                  chain_rdata;
   logic                         core_start;
   sha_pkg::core_port_type       core_port;

   // Block buffer and chain value memories
   sha_ram #(.WIDTH(32), .DEPTH(sha_pkg::BLOCK_WORDS)) u_block_buf (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .raddr (core_port.buf_raddr),
      .rdata (buf_rdata)
   );

   sha_ram #(.WIDTH(32), .DEPTH(sha_pkg::CHAIN_WORDS)) u_chain (
      .clock (clock),
      .we    (core_port.chain_we),
      .waddr (core_port.chain_waddr),
      .wdata (core_port.chain_wdata),
      .raddr (chain_raddr),
      .rdata (chain_ram_rdata)
   );

   sha_core u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (core_start),
      .buf_rdata   (buf_rdata),
      .chain_rdata (chain_rdata),
      .port        (core_port)
   );

   // Chain reads as the initial hash until a message's first block is folded in
   assign chain_rdata = fresh_ff ? sha_pkg::INIT_H[raddr_q_ff] : chain_ram_rdata;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tuser  = rsp_num_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Byte lane merge, big-endian within the word
   always_comb begin
      pos     = count_ff[5:0];
      end_pos = req_tuser ? (pos + 6'd1) : pos;
      unique case (pos[1:0])
         2'd0:    byte_word = {req_tdata, word_ff[23:0]};
         2'd1:    byte_word = {word_ff[31:24], req_tdata, word_ff[15:0]};
         2'd2:    byte_word = {word_ff[31:16], req_tdata, word_ff[7:0]};
         default: byte_word = {word_ff[31:8], req_tdata};
      endcase
   end

   // Padding words: partial word with 0x80 marker, zeros, then the bit length
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (2'(l) < count_ff[1:0]) begin
            pad_word[8*(3-l) +: 8] = word_ff[8*(3-l) +: 8];
         end else if (2'(l) == count_ff[1:0]) begin
            pad_word[8*(3-l) +: 8] = sha_pkg::PAD_BYTE;
         end else begin
            pad_word[8*(3-l) +: 8] = 8'd0;
         end
      end
      if (pad_first_ff) begin
         pad_data = pad_word;
      end else if (!pad_two_ff && (widx_ff == WIDX_LEN_HI)) begin
         pad_data = count_ff[60:29];
      end else if (!pad_two_ff && (widx_ff == WIDX_LAST)) begin
         pad_data = {count_ff[28:0], 3'b000};
      end else begin
         pad_data = 32'd0;
      end
   end

   // Control sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      end_in       = end_ff;
      pad_two_in   = pad_two_ff;
      pad_first_in = pad_first_ff;
      widx_in      = widx_ff;
      final_in     = final_ff;
      fresh_in     = fresh_ff;
      onum_in      = onum_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      buf_we       = 1'b0;
      buf_waddr    = pos[5:2];
      buf_wdata    = byte_word;
      core_start   = 1'b0;
      chain_raddr  = core_port.chain_raddr;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser) begin
                  word_in  = byte_word;
                  count_in = count_ff + 61'd1;
                  buf_we   = (pos[1:0] == 2'd3);
               end
               if (req_tuser && (pos == POS_LAST_BYTE)) begin
                  core_start = 1'b1;
                  final_in   = 1'b0;
                  end_in     = req_tlast;
                  state_in   = ST_COMP;
               end else if (req_tlast) begin
                  widx_in      = end_pos[5:2];
                  pad_first_in = 1'b1;
                  pad_two_in   = (end_pos >= POS_NO_LENGTH);
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            buf_we       = 1'b1;
            buf_waddr    = widx_ff;
            buf_wdata    = pad_data;
            pad_first_in = 1'b0;
            if (widx_ff == WIDX_LAST) begin
               core_start = 1'b1;
               final_in   = !pad_two_ff;
               state_in   = ST_COMP;
            end else begin
               widx_in = widx_ff + 4'd1;
            end
         end
         ST_COMP: begin
            if (core_port.done) begin
               fresh_in = 1'b0;
               if (final_ff) begin
                  count_in = '0;
                  onum_in  = 3'd0;
                  state_in = ST_OUT_RD;
               end else if (pad_two_ff) begin
                  // length goes into a second padding block
                  pad_two_in   = 1'b0;
                  widx_in      = 4'd0;
                  pad_first_in = 1'b0;
                  state_in     = ST_PAD;
               end else if (end_ff) begin
                  // message ended on a block boundary
                  end_in       = 1'b0;
                  widx_in      = 4'd0;
                  pad_first_in = 1'b1;
                  state_in     = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUT_RD: begin
            chain_raddr = onum_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            rsp_word_in  = chain_rdata;
            rsp_num_in   = onum_ff;
            rsp_last_in  = (onum_ff == ONUM_LAST);
            rsp_valid_in = 1'b1;
            if (onum_ff == ONUM_LAST) begin
               fresh_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               onum_in  = onum_ff + 3'd1;
               state_in = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         end_ff       <= 1'b0;
         pad_two_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         widx_ff      <= 4'd0;
         final_ff     <= 1'b0;
         fresh_ff     <= 1'b1;
         onum_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         pad_two_ff   <= pad_two_in;
         pad_first_ff <= pad_first_in;
         widx_ff      <= widx_in;
         final_ff     <= final_in;
         fresh_ff     <= fresh_in;
         onum_ff      <= onum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      raddr_q_ff  <= chain_raddr;
      rsp_word_ff <= rsp_word_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   // the engine only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      core_port.done |-> (state_ff == ST_COMP))
      else $error("compression done outside of compress state");

   // output register is free whenever a digest word is loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_LD) |-> !rsp_valid_ff)
      else $error("digest word overwrites a pending beat");

   // byte count restarts after the final block
   assert property (@(posedge clock) disable iff (reset)
      (core_port.done && final_ff) |=> (count_ff == '0))
      else $error("byte count not cleared after final block");

   // last beat carries the last word position
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_num_ff == ONUM_LAST))
      else $error("last flag on wrong digest word");

   // chain returns to the initial hash only after the digest is read out
   assert property (@(posedge clock) disable iff (reset)
      $rose(fresh_ff) |-> ($past(state_ff) == ST_OUT_LD))
      else $error("chain reinitialized mid-message");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the SHA-256 message hasher: byte stream in, digest words out.
module tb_top;

   localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
   localparam int QUIET_TAIL  = 40;     // last beats sent with no idling
   localparam int DRAIN_WAIT  = 200;    // padding plus two compressions plus digest out

   // FIPS 180-4 round constants
   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_present;
      logic       ends_msg;
      logic       wait_drain;     // hold this beat until every digest word is back
   } req_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   req_beat_type    pending [$];
   req_beat_type    on_bus;
   digest_beat_type digest_expect [$];
   digest_beat_type want;
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              send_gap = 0;
   int              recv_stall = 0;

   // Running hash state
   logic [31:0] hash_state [8];
   logic [31:0] msg_block [16];
   logic [60:0] byte_total;

   sha256_message_hasher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      byte_total = '0;
   endtask

   // One 64-round compression of msg_block into hash_state
   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      for (int i = 16; i < 64; i++)
         w[i] = (rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10))
              + w[i-7]
              + (rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
            + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
         t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
            + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Byte position 0 lands in the top byte of word 0
   task automatic put_msg_byte(input int pos, input logic [7:0] value);
      msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = value;
   endtask

   // Advance the hash by one accepted beat; queue the digest on a message end
   task automatic absorb_beat(input req_beat_type beat);
      int          pos;
      logic [63:0] bit_len;
      if (beat.byte_present) begin
         pos = int'(byte_total[5:0]);
         put_msg_byte(pos, beat.msg_byte);
         byte_total = byte_total + 1'b1;
         if (pos == 63) fold_block();
      end
      if (beat.ends_msg) begin
         pos = int'(byte_total[5:0]);
         put_msg_byte(pos, sha_pkg::PAD_BYTE);
         for (int i = pos + 1; i < 64; i++) put_msg_byte(i, 8'h00);
         // no room for the length: close this block and pad a fresh one
         if (pos >= 56) begin
            fold_block();
            for (int i = 0; i < 16; i++) msg_block[i] = '0;
         end
         bit_len = {byte_total, 3'b000};
         msg_block[14] = bit_len[63:32];
         msg_block[15] = bit_len[31:0];
         fold_block();
         for (int i = 0; i < 8; i++)
            digest_expect.push_back('{digest_word: hash_state[i],
                                      word_number: 3'(i),
                                      last_word:   (i == 7)});
         restart_message();
      end
   endtask

   task automatic push_beat(input logic [7:0] data, input logic present,
                            input logic ends, input logic drain);
      pending.push_back('{msg_byte: data, byte_present: present,
                          ends_msg: ends, wait_drain: drain});
   endtask

   // Random-content message with stray empty beats; the end rides on the
   // last byte or comes as a beat of its own
   task automatic add_message(input int length, input logic drain);
      logic first;
      first = drain;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            push_beat(8'($urandom), 1'b0, 1'b0, first);
            first = 1'b0;
         end
         push_beat(8'($urandom), 1'b1, (i == length - 1) && $urandom_range(0, 1) == 1, first);
         first = 1'b0;
      end
      if (length == 0 || !pending[$].ends_msg)
         push_beat(8'($urandom), 1'b0, 1'b1, first);
   endtask

   // Driver: one beat per handshake, random idle bursts until the tail
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         restart_message();
      end else begin
         if (req_tvalid && req_tready) absorb_beat(on_bus);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending.size() == 0 ||
                         (pending[0].wait_drain && digest_expect.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
               send_gap = $urandom_range(0, 9);
               req_tvalid <= 1'b0;
            end else begin
               on_bus = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= on_bus.msg_byte;
               req_tuser  <= on_bus.byte_present;
               req_tlast  <= on_bus.ends_msg;
            end
         end
      end
   end

   // Monitor: digest beats against the oldest expected word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (digest_expect.size() == 0) begin
               if (error_count < 10)
                  $display("digest beat with nothing expected: word %0d data %h last %b",
                           rsp_tuser, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               want = digest_expect.pop_front();
               if (rsp_tdata !== want.digest_word || rsp_tuser !== want.word_number ||
                   rsp_tlast !== want.last_word) begin
                  if (error_count < 10)
                     $display("digest mismatch: expected word %0d %h last %b, got word %0d %h last %b",
                              want.word_number, want.digest_word, want.last_word,
                              rsp_tuser, rsp_tdata, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            recv_stall = $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("no beat for %0d cycles", quiet_cycles);
         $display("** sha256_message_hasher: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Directed: empty beat, empty message, "abc" ending on its last byte,
      // byte extremes, end beat without a byte, ignored data on empty beats
      push_beat(8'hff, 1'b0, 1'b0, 1'b0);
      push_beat(8'h00, 1'b0, 1'b1, 1'b0);
      push_beat(8'h61, 1'b1, 1'b0, 1'b0);
      push_beat(8'h62, 1'b1, 1'b0, 1'b0);
      push_beat(8'h63, 1'b1, 1'b1, 1'b0);
      push_beat(8'hff, 1'b1, 1'b1, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0, 1'b0);
      push_beat(8'hff, 1'b0, 1'b0, 1'b0);
      push_beat(8'h00, 1'b1, 1'b0, 1'b0);
      push_beat(8'hff, 1'b1, 1'b0, 1'b0);
      push_beat(8'ha5, 1'b0, 1'b1, 1'b0);
      push_beat(8'hff, 1'b0, 1'b1, 1'b0);

      // Random: short messages, then a full block and a two-block pad case
      add_message($urandom_range(0, 12), 1'b1);
      repeat (5) add_message($urandom_range(0, 12), 1'b0);
      add_message(64, 1'b1);
      add_message($urandom_range(56, 63), 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending.size() != 0 || req_tvalid) @(posedge clock);
      while (digest_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0 && digest_expect.size() == 0) begin
         $display("** sha256_message_hasher: PASSED **");
      end else begin
         $display("%0d mismatches, %0d digest words missing", error_count,
                  digest_expect.size());
         $display("** sha256_message_hasher: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sha256_message_hasher.f
design/sha_pkg.sv
design/sha_ram.sv
design/sha_core.sv
design/sha256_message_hasher.sv
tb/tb_top.sv
